@@ rtl/ip_route_trie_lookup_top_macros.svh @@
// ---------------------------------------------------------------------------
// ip_route_trie_lookup_top_macros
// Assertion macros shared by the route trie lookup modules.
// ---------------------------------------------------------------------------
`ifndef IP_ROUTE_TRIE_LOOKUP_TOP_MACROS_SVH
`define IP_ROUTE_TRIE_LOOKUP_TOP_MACROS_SVH

// same-cycle implication
`define IPRT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPRT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/iprt_pkg.sv @@
// ---------------------------------------------------------------------------
// iprt_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package iprt_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int PLEN_W      = 6;
  localparam int PORT_W      = 8;
  localparam int PORT_REC_W  = PORT_W + 1;  // valid + port
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic load;
    logic lk_step;
    logic dry_step;
    logic dry_last;
    logic cnt_step;
    logic commit_start;
    logic commit_step;
    logic commit_last;
    logic exp_step;
    logic exp_wr;
    logic exp_fin;
    logic emit;
    logic emit_full;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic lk_end;
    logic walk_more;
    logic broken;
    logic slot_zero;
    logic last_slot;
    logic pool_full;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/iprt_ram.sv @@
// ---------------------------------------------------------------------------
// iprt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module iprt_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/iprt_ctrl.sv @@
// ---------------------------------------------------------------------------
// iprt_ctrl
// Sequencer for lookup, insert dry walk, pool check, commit and expansion.
// ---------------------------------------------------------------------------
`include "ip_route_trie_lookup_top_macros.svh"

module iprt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  iprt_pkg::sts_t sts,
  output iprt_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_LOOKUP  = 11'b000_0000_0010,
    ST_DRY     = 11'b000_0000_0100,
    ST_COUNT   = 11'b000_0000_1000,
    ST_CHECK   = 11'b000_0001_0000,
    ST_WALK    = 11'b000_0010_0000,
    ST_EXPAND  = 11'b000_0100_0000,
    ST_EXP_WR  = 11'b000_1000_0000,
    ST_EXP_FIN = 11'b001_0000_0000,
    ST_DONE    = 11'b010_0000_0000,
    ST_REFUSE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (sts.in_op == iprt_pkg::OP_LOOKUP) ? ST_LOOKUP : ST_DRY;
        end
      end
      ST_LOOKUP: begin
        cmd.lk_step = 1'b1;
        if (sts.lk_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DRY: begin
        if (sts.walk_more) begin
          cmd.dry_step = 1'b1;
        end else begin
          cmd.dry_last = 1'b1;
          state_nxt    = sts.broken ? ST_CHECK : ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.cnt_step = 1'b1;
        if (sts.last_slot) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.pool_full) begin
          state_nxt = ST_REFUSE;
        end else begin
          cmd.commit_start = 1'b1;
          state_nxt        = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_more) begin
          cmd.commit_step = 1'b1;
        end else begin
          cmd.commit_last = 1'b1;
          state_nxt       = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        if (!sts.slot_zero) begin
          state_nxt = ST_EXP_WR;
        end else if (sts.last_slot) begin
          state_nxt = ST_EXP_FIN;
        end
      end
      ST_EXP_WR: begin
        cmd.exp_wr = 1'b1;
        state_nxt  = sts.last_slot ? ST_EXP_FIN : ST_EXPAND;
      end
      ST_EXP_FIN: begin
        cmd.exp_fin = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REFUSE: begin
        if (!sts.out_busy) begin
          cmd.emit_full = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `IPRT_ASSERT_IMP(a_cmd_excl, clk, rst_n, 1'b1, $onehot0(cmd), "more than one datapath command")
  `IPRT_ASSERT_NXT(a_req_start, clk, rst_n, in_tvalid && in_tready, (state_r == ST_LOOKUP || state_r == ST_DRY), "request did not start a walk")

endmodule

@@ rtl/iprt_dp.sv @@
// ---------------------------------------------------------------------------
// iprt_dp
// Trie datapath: node memory, walk registers, pool counter, result register.
// ---------------------------------------------------------------------------
`include "ip_route_trie_lookup_top_macros.svh"

module iprt_dp #(
  parameter int STRIDE_BITS = 1,
  parameter int NODE_POOL   = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [iprt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tuser,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [iprt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  iprt_pkg::cmd_t                     cmd,
  output iprt_pkg::sts_t                     sts
);

  localparam int FANOUT = 1 << STRIDE_BITS;
  localparam int IDXW   = $clog2(NODE_POOL);
  localparam int CNTW   = $clog2(NODE_POOL + 1);
  localparam int KIDS_W = FANOUT * IDXW;
  localparam int NODE_W = KIDS_W + iprt_pkg::PORT_REC_W;
  localparam int NEEDW  = $clog2(iprt_pkg::ADDR_BITS + FANOUT + 1);
  localparam int SUMW   = ((CNTW > NEEDW) ? CNTW : NEEDW) + 1;
  localparam int AB     = iprt_pkg::ADDR_BITS;
  localparam int PW     = iprt_pkg::PLEN_W;
  localparam int RW     = iprt_pkg::PORT_REC_W;

  // request fields
  logic [AB-1:0]                 in_addr;
  logic [PW-1:0]                 in_plen;
  logic [iprt_pkg::PORT_W-1:0]   in_port;

  assign in_addr = in_tdata[AB-1:0];
  assign in_plen = in_tdata[AB+PW-1:AB];
  assign in_port = in_tdata[AB+PW+iprt_pkg::PORT_W-1:AB+PW];

  // walk state
  logic                          op_r;
  logic [AB-1:0]                 addr_r;
  logic [AB-1:0]                 sh_r;
  logic [PW-1:0]                 plen_r;
  logic [PW-1:0]                 pos_r;
  logic [iprt_pkg::PORT_W-1:0]   port_r;
  logic [RW-1:0]                 best_r;
  logic [NEEDW-1:0]              need_r;
  logic                          broken_r;
  logic                          fresh_r;
  logic [IDXW-1:0]               node_r;
  logic [FANOUT-1:0][IDXW-1:0]   data_kids_r;
  logic [RW-1:0]                 data_port_r;
  logic [STRIDE_BITS-1:0]        slot_r;
  logic [STRIDE_BITS:0]          rem_r;
  logic [CNTW-1:0]               used_r;
  logic                          root_init_r;
  logic                          zero_rd_r;

  // result register
  logic                          out_valid_r;
  logic                          hit_r;
  logic [iprt_pkg::PORT_W-1:0]   oport_r;
  logic                          status_r;

  // memory port
  logic                          ram_we;
  logic [IDXW-1:0]               ram_waddr;
  logic [NODE_W-1:0]             ram_wdata;
  logic                          ram_re;
  logic [IDXW-1:0]               ram_raddr;
  logic [NODE_W-1:0]             ram_rdata;
  logic [NODE_W-1:0]             rd_eff;

  // derived
  logic [STRIDE_BITS-1:0]        digit;
  logic [FANOUT-1:0][IDXW-1:0]   cur_kids;
  logic [FANOUT-1:0][IDXW-1:0]   wr_kids;
  logic [RW-1:0]                 cur_port;
  logic [IDXW-1:0]               cur_child;
  logic                          child_zero;
  logic [PW:0]                   pos_step;
  logic [PW:0]                   spare;
  logic [STRIDE_BITS:0]          span;
  logic [STRIDE_BITS:0]          span_mask;
  logic [STRIDE_BITS-1:0]        key;
  logic [IDXW-1:0]               sl_child;
  logic                          sl_zero;
  logic                          lk_more;
  logic [IDXW-1:0]               new_idx;
  logic [CNTW-1:0]               waddr_ext;

  iprt_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODE_POOL)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // root reads as empty until first written
  assign rd_eff     = zero_rd_r ? '0 : ram_rdata;
  assign cur_kids   = fresh_r ? '0 : rd_eff[KIDS_W-1:0];
  assign cur_port   = fresh_r ? '0 : rd_eff[NODE_W-1:KIDS_W];
  assign digit      = sh_r[AB-1 -: STRIDE_BITS];
  assign cur_child  = cur_kids[digit];
  assign child_zero = (cur_child == '0);
  assign pos_step   = {1'b0, pos_r} + (PW+1)'(STRIDE_BITS);
  assign spare      = pos_step - {1'b0, plen_r};
  assign span       = (STRIDE_BITS+1)'(1) << spare;
  assign span_mask  = span - (STRIDE_BITS+1)'(1);
  assign key        = digit & ~span_mask[STRIDE_BITS-1:0];
  assign sl_child   = data_kids_r[slot_r];
  assign sl_zero    = (sl_child == '0);
  assign lk_more    = (pos_r < PW'(AB));
  assign new_idx    = used_r[IDXW-1:0];
  assign waddr_ext  = CNTW'(ram_waddr);

  assign sts.in_op     = in_tuser;
  assign sts.lk_end    = !lk_more || child_zero;
  assign sts.walk_more = (pos_step < {1'b0, plen_r});
  assign sts.broken    = broken_r;
  assign sts.slot_zero = sl_zero;
  assign sts.last_slot = (rem_r == (STRIDE_BITS+1)'(1));
  assign sts.pool_full = (SUMW'(used_r) + SUMW'(need_r)) > SUMW'(NODE_POOL);
  assign sts.out_busy  = out_valid_r && !out_tready;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd.load || cmd.commit_start) begin
      ram_re = 1'b1;
    end else if ((cmd.lk_step && lk_more && !child_zero) ||
                 (cmd.dry_step && !broken_r && !child_zero) ||
                 (cmd.commit_step && !child_zero)) begin
      ram_re    = 1'b1;
      ram_raddr = cur_child;
    end else if (cmd.exp_step && !sl_zero) begin
      ram_re    = 1'b1;
      ram_raddr = sl_child;
    end
  end

  always_comb begin
    wr_kids        = cur_kids;
    wr_kids[digit] = new_idx;
    ram_we         = 1'b0;
    ram_waddr      = node_r;
    ram_wdata      = {cur_port, wr_kids};
    if (cmd.commit_step && child_zero) begin
      ram_we = 1'b1;
    end else if (cmd.exp_step && sl_zero) begin
      ram_we    = 1'b1;
      ram_waddr = new_idx;
      ram_wdata = {1'b1, port_r, {KIDS_W{1'b0}}};
    end else if (cmd.exp_wr) begin
      ram_we    = 1'b1;
      ram_waddr = sl_child;
      ram_wdata = {1'b1, port_r, rd_eff[KIDS_W-1:0]};
    end else if (cmd.exp_fin) begin
      ram_we    = 1'b1;
      ram_wdata = {data_port_r, data_kids_r};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= CNTW'(1);
      root_init_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((cmd.commit_step && child_zero) || (cmd.exp_step && sl_zero)) begin
        used_r <= used_r + CNTW'(1);
      end
      if (ram_we && ram_waddr == '0) begin
        root_init_r <= 1'b1;
      end
      if (cmd.emit || cmd.emit_full) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ram_re) begin
      zero_rd_r <= (ram_raddr == '0) && !root_init_r;
    end
    if (cmd.load) begin
      op_r     <= in_tuser;
      addr_r   <= in_addr;
      sh_r     <= in_addr;
      plen_r   <= (in_plen > PW'(AB)) ? PW'(AB) : in_plen;
      port_r   <= in_port;
      pos_r    <= '0;
      best_r   <= '0;
      need_r   <= '0;
      broken_r <= 1'b0;
      fresh_r  <= 1'b0;
      node_r   <= '0;
    end
    if (cmd.lk_step) begin
      if (cur_port[RW-1]) begin
        best_r <= cur_port;
      end
      if (lk_more && !child_zero) begin
        pos_r <= pos_step[PW-1:0];
        sh_r  <= sh_r << STRIDE_BITS;
      end
    end
    if (cmd.dry_step) begin
      if (broken_r || child_zero) begin
        broken_r <= 1'b1;
        need_r   <= need_r + NEEDW'(1);
      end
      pos_r <= pos_step[PW-1:0];
      sh_r  <= sh_r << STRIDE_BITS;
    end
    if (cmd.dry_last) begin
      if (broken_r) begin
        need_r <= need_r + NEEDW'(span);
      end else begin
        data_kids_r <= cur_kids;
        slot_r      <= key;
        rem_r       <= span;
      end
    end
    if (cmd.cnt_step) begin
      if (sl_zero) begin
        need_r <= need_r + NEEDW'(1);
      end
      slot_r <= slot_r + STRIDE_BITS'(1);
      rem_r  <= rem_r - (STRIDE_BITS+1)'(1);
    end
    if (cmd.commit_start) begin
      pos_r   <= '0;
      sh_r    <= addr_r;
      node_r  <= '0;
      fresh_r <= 1'b0;
    end
    if (cmd.commit_step) begin
      if (child_zero) begin
        node_r  <= new_idx;
        fresh_r <= 1'b1;
      end else begin
        node_r  <= cur_child;
        fresh_r <= 1'b0;
      end
      pos_r <= pos_step[PW-1:0];
      sh_r  <= sh_r << STRIDE_BITS;
    end
    if (cmd.commit_last) begin
      data_kids_r <= cur_kids;
      data_port_r <= cur_port;
      slot_r      <= key;
      rem_r       <= span;
    end
    if ((cmd.exp_step && sl_zero) || cmd.exp_wr) begin
      slot_r <= slot_r + STRIDE_BITS'(1);
      rem_r  <= rem_r - (STRIDE_BITS+1)'(1);
    end
    if (cmd.exp_step && sl_zero) begin
      data_kids_r[slot_r] <= new_idx;
    end
    if (cmd.emit) begin
      hit_r    <= (op_r == iprt_pkg::OP_LOOKUP) && best_r[RW-1];
      oport_r  <= (op_r == iprt_pkg::OP_LOOKUP) ? best_r[RW-2:0] : '0;
      status_r <= 1'b0;
    end else if (cmd.emit_full) begin
      hit_r    <= 1'b0;
      oport_r  <= '0;
      status_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(iprt_pkg::OUT_TDATA_W - iprt_pkg::PORT_W - 2){1'b0}},
                       status_r, oport_r, hit_r};

  `IPRT_ASSERT_IMP(a_wr_in_pool, clk, rst_n, ram_we, waddr_ext <= used_r, "node write beyond allocated pool")
  `IPRT_ASSERT_NXT(a_used_mono, clk, rst_n, 1'b1, (used_r == $past(used_r) || used_r == $past(used_r) + CNTW'(1)), "node count jumped")

endmodule

@@ rtl/ip_route_trie_lookup_top.sv @@
// ---------------------------------------------------------------------------
// ip_route_trie_lookup_top
// IPv4 longest-prefix-match engine on a fixed-stride multibit trie.
// ---------------------------------------------------------------------------
// Channel  Dir  Ports                      Contents
// in_      in   tvalid tready tdata tuser  insert or lookup request
// out_     out  tvalid tready tdata        hit, port, pool-full status
//
// One request at a time; the node RAM gives one node access per cycle.
// Lookup: walks the trie one level at a time from the root.
// Insert: dry walk, count of empty covered slots when the whole path exists,
//   pool check, commit walk, then expansion over the covered slots.
// Reset holds only the pool counter, root flag and handshake state; no sweep.
// A stalled result sits in the output register; the next request waits for it
//   only when its own result is ready.
// ---------------------------------------------------------------------------
module ip_route_trie_lookup_top #(
  parameter int STRIDE_BITS = 1,
  parameter int NODE_POOL   = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [iprt_pkg::IN_TDATA_W-1:0]  in_tdata,   // ip_addr, prefix_len, route_port
  input  logic                             in_tuser,   // op
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [iprt_pkg::OUT_TDATA_W-1:0] out_tdata   // hit, out_port, status
);

  iprt_pkg::cmd_t cmd;
  iprt_pkg::sts_t sts;

  iprt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iprt_dp #(
    .STRIDE_BITS(STRIDE_BITS),
    .NODE_POOL  (NODE_POOL)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
